[rtl/multi_channel_soft_pwm_timer_assert.svh]
// assertion macros shared by the rtl
`ifndef MULTI_CHANNEL_SOFT_PWM_TIMER_ASSERT_SVH
`define MULTI_CHANNEL_SOFT_PWM_TIMER_ASSERT_SVH

// condition implies consequence in the same cycle
`define MCSPT_ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("mcspt assertion failed");

// condition implies consequence in the next cycle
`define MCSPT_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("mcspt assertion failed");

`endif

[rtl/mcspt_pkg.sv]
`default_nettype none

package mcspt_pkg;

    localparam int CHANNELS = 8;
    localparam int CH_W     = 3;
    localparam int VAL_W    = 32;
    localparam int EV_W     = 8;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;

    localparam logic [VAL_W-1:0] COUNT_MAX = {VAL_W{1'b1}};
    localparam logic [VAL_W-1:0] REPEAT_LAST = VAL_W'(1);

    typedef enum logic [2:0] {
        CMD_TICK        = 3'd0,
        CMD_START       = 3'd1,
        CMD_STOP        = 3'd2,
        CMD_RESTART     = 3'd3,
        CMD_SET_PERIOD  = 3'd4,
        CMD_SET_COMPARE = 3'd5,
        CMD_SET_REPEAT  = 3'd6
    } cmd_t;

endpackage

`default_nettype wire

[rtl/multi_channel_soft_pwm_timer.sv]
// Multi-channel software PWM timer. Up to CHANNELS (8) channels each keep an
// elapsed tick count, period, compare point, repeat count, running flag and
// compare-done flag. Items arrive on the s_ stream: tuser carries the command
// (tick, start, stop, restart count, set period, set compare, set repeat) and
// tdata the channel and 32-bit value. A tick advances every running channel
// at once (saturating at all ones), flags a compare event once per period,
// and a period event when the count reaches the period; after a period event
// repeat 0 runs forever, repeat above 1 counts down and restarts, repeat 1
// stops the channel and flags it finished. Every item, tick or not, yields
// exactly one result item on the m_ stream with the three event masks and the
// running mask after the item; non-tick items report zero events. Timing: one
// item per clock sustained while m_tready is high; an accepted item passes
// through the input register, then the per-channel update logic writes the
// state and the result register in the same edge. The result register lets
// a new item be taken while an earlier result is still waiting on m_tready.
`default_nettype none

module multi_channel_soft_pwm_timer
    import mcspt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // channel [2:0], value [34:3], zero [39:35]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // cmd [2:0]
    input  wire logic [2:0]            s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // compare_events [7:0], period_events [15:8], finished_events [23:16],
    // active_mask [31:24]
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    // input register stage
    logic              in_valid_reg;
    cmd_t              in_cmd_reg;
    logic [CH_W-1:0]   in_chan_reg;
    logic [VAL_W-1:0]  in_value_reg;

    // result register stage
    logic                   out_valid_reg;
    logic [OUT_DATA_W-1:0]  out_data_reg;

    // per-channel state
    logic [VAL_W-1:0]  elapsed_reg [CHANNELS];
    logic [VAL_W-1:0]  period_reg  [CHANNELS];
    logic [VAL_W-1:0]  compare_reg [CHANNELS];
    logic [VAL_W-1:0]  repeat_reg  [CHANNELS];
    logic [CHANNELS-1:0] running_reg;
    logic [CHANNELS-1:0] done_reg;

    logic [VAL_W-1:0]  elapsed_next [CHANNELS];
    logic [VAL_W-1:0]  period_next  [CHANNELS];
    logic [VAL_W-1:0]  compare_next [CHANNELS];
    logic [VAL_W-1:0]  repeat_next  [CHANNELS];
    logic [CHANNELS-1:0] running_next;
    logic [CHANNELS-1:0] done_next;

    logic [CHANNELS-1:0] cmp_vec;
    logic [CHANNELS-1:0] per_vec;
    logic [CHANNELS-1:0] fin_vec;

    logic advance;
    logic s_accept;

    // the item in the input register moves on when the result slot is free
    // or is being emptied in this cycle
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_cmd_reg   <= cmd_t'(s_tuser);
            in_chan_reg  <= s_tdata[CH_W-1:0];
            in_value_reg <= s_tdata[CH_W+VAL_W-1:CH_W];
        end
    end

    // per-channel update, all channels side by side
    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_chan
        logic [VAL_W-1:0] el_inc;
        logic             sel;
        logic             cmp_hit;
        logic             per_hit;

        assign sel    = (in_chan_reg == CH_W'(c));
        // saturating increment
        assign el_inc = (elapsed_reg[c] == COUNT_MAX) ? elapsed_reg[c]
                                                      : elapsed_reg[c] + VAL_W'(1);
        assign cmp_hit = running_reg[c] && !done_reg[c] && (el_inc >= compare_reg[c]);
        assign per_hit = running_reg[c] && (el_inc >= period_reg[c]);

        always_comb
        begin
            elapsed_next[c] = elapsed_reg[c];
            period_next[c]  = period_reg[c];
            compare_next[c] = compare_reg[c];
            repeat_next[c]  = repeat_reg[c];
            running_next[c] = running_reg[c];
            done_next[c]    = done_reg[c];
            cmp_vec[c]      = 1'b0;
            per_vec[c]      = 1'b0;
            fin_vec[c]      = 1'b0;
            case (in_cmd_reg)
                CMD_TICK:
                begin
                    if (running_reg[c])
                    begin
                        elapsed_next[c] = el_inc;
                        cmp_vec[c]      = cmp_hit;
                        if (cmp_hit)
                        begin
                            done_next[c] = 1'b1;
                        end
                        if (per_hit)
                        begin
                            per_vec[c]   = 1'b1;
                            done_next[c] = 1'b0;
                            if (repeat_reg[c] == REPEAT_LAST)
                            begin
                                // last repeat: stop, count stays where it got to
                                running_next[c] = 1'b0;
                                fin_vec[c]      = 1'b1;
                            end
                            else
                            begin
                                if (repeat_reg[c] > REPEAT_LAST)
                                begin
                                    repeat_next[c] = repeat_reg[c] - VAL_W'(1);
                                end
                                elapsed_next[c] = '0;
                            end
                        end
                    end
                end
                CMD_START:
                begin
                    if (sel)
                    begin
                        elapsed_next[c] = '0;
                        done_next[c]    = 1'b0;
                        running_next[c] = 1'b1;
                    end
                end
                CMD_STOP:
                begin
                    if (sel)
                    begin
                        running_next[c] = 1'b0;
                    end
                end
                CMD_RESTART:
                begin
                    if (sel)
                    begin
                        elapsed_next[c] = '0;
                    end
                end
                CMD_SET_PERIOD:
                begin
                    if (sel)
                    begin
                        period_next[c] = in_value_reg;
                    end
                end
                CMD_SET_COMPARE:
                begin
                    if (sel)
                    begin
                        compare_next[c] = in_value_reg;
                    end
                end
                CMD_SET_REPEAT:
                begin
                    if (sel)
                    begin
                        repeat_next[c] = in_value_reg;
                    end
                end
                default:
                begin
                    // unused command code: no change
                end
            endcase
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                elapsed_reg[c] <= '0;
                period_reg[c]  <= '0;
                compare_reg[c] <= '0;
                repeat_reg[c]  <= '0;
                running_reg[c] <= 1'b0;
                done_reg[c]    <= 1'b0;
            end
            else if (advance)
            begin
                elapsed_reg[c] <= elapsed_next[c];
                period_reg[c]  <= period_next[c];
                compare_reg[c] <= compare_next[c];
                repeat_reg[c]  <= repeat_next[c];
                running_reg[c] <= running_next[c];
                done_reg[c]    <= done_next[c];
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {EV_W'(running_next), EV_W'(fin_vec),
                             EV_W'(per_vec), EV_W'(cmp_vec)};
        end
    end

    // views used by the checks below
    logic                    in_stall;
    logic                    adv_non_tick;
    logic [CH_W+VAL_W-1:0]   in_held;
    logic [3*EV_W-1:0]       res_events;
    logic [EV_W-1:0]         res_per;
    logic [EV_W-1:0]         res_fin;
    logic [EV_W-1:0]         res_act;

    assign in_stall     = in_valid_reg && !advance;
    assign adv_non_tick = advance && (in_cmd_reg != CMD_TICK);
    assign in_held      = {in_value_reg, in_chan_reg};
    assign res_events   = out_data_reg[3*EV_W-1:0];
    assign res_per      = out_data_reg[2*EV_W-1:EV_W];
    assign res_fin      = out_data_reg[3*EV_W-1:2*EV_W];
    assign res_act      = out_data_reg[4*EV_W-1:3*EV_W];

`include "multi_channel_soft_pwm_timer_assert.svh"

    // a stalled input item stays put until the result slot frees up
    `MCSPT_ASSERT_NEXT(a_in_hold, clk, rst_n, in_stall, in_valid_reg && $stable(in_held))
    // finishing only happens on a period end
    `MCSPT_ASSERT_SAME(a_fin_in_period, clk, rst_n, out_valid_reg, (res_fin & ~res_per) == '0)
    // a finished channel is no longer running
    `MCSPT_ASSERT_SAME(a_fin_stopped, clk, rst_n, out_valid_reg, (res_fin & res_act) == '0)
    // commands other than tick report no events
    `MCSPT_ASSERT_NEXT(a_no_ev_cmd, clk, rst_n, adv_non_tick, res_events == '0)

endmodule

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import mcspt_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int RESET_LEN   = 12;
    localparam int CYCLE_LIMIT = 300000;
    // accept to result through the input and result registers, plus margin
    localparam int SETTLE_CYCLES = 10;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int PRINT_LIMIT   = 50;

    // the package enum stops at 6, code 7 is the unused one
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    // event masks for one result item
    typedef struct packed {
        logic [EV_W-1:0] compare_events;
        logic [EV_W-1:0] period_events;
        logic [EV_W-1:0] finished_events;
        logic [EV_W-1:0] active_mask;
    } masks_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // channel [2:0], value [34:3], zero [39:35]
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    // cmd [2:0]
    logic [2:0]            s_tuser = 3'd0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // compare_events [7:0], period_events [15:8], finished_events [23:16],
    // active_mask [31:24]
    logic [OUT_DATA_W-1:0] m_tdata;

    multi_channel_soft_pwm_timer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // shadow copy of the per-channel timer state
    logic [VAL_W-1:0] elapsed_ticks [CHANNELS];
    logic [VAL_W-1:0] period_ticks  [CHANNELS];
    logic [VAL_W-1:0] compare_ticks [CHANNELS];
    logic [VAL_W-1:0] repeats_left  [CHANNELS];
    logic             chan_running  [CHANNELS];
    logic             compare_hit   [CHANNELS];

    // event masks still owed by the block, oldest first
    masks_t expected_masks[$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  items_sent     = 0;
    int  ticks_sent     = 0;
    int  results_seen   = 0;
    int  period_seen    = 0;
    int  finished_seen  = 0;
    bit  src_gaps       = 1'b1;
    bit  sink_stalls    = 1'b1;
    int  sink_hold      = 0;

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 8);
        else
            return $urandom_range(12, 40);
    endfunction

    // apply one item to the shadow state and return the masks it must produce
    function automatic masks_t timer_step(input logic [2:0] cmd,
                                          input logic [CH_W-1:0] ch,
                                          input logic [VAL_W-1:0] val);
        masks_t m;
        m = '0;
        if (cmd == CMD_TICK) begin
            for (int c = 0; c < CHANNELS; c++) begin
                if (chan_running[c]) begin
                    // elapsed count holds at all ones
                    if (elapsed_ticks[c] != COUNT_MAX)
                        elapsed_ticks[c] = elapsed_ticks[c] + 1'b1;
                    // compare fires once per period
                    if (!compare_hit[c] && elapsed_ticks[c] >= compare_ticks[c]) begin
                        m.compare_events[c] = 1'b1;
                        compare_hit[c] = 1'b1;
                    end
                    if (elapsed_ticks[c] >= period_ticks[c]) begin
                        m.period_events[c] = 1'b1;
                        compare_hit[c] = 1'b0;
                        if (repeats_left[c] == REPEAT_LAST) begin
                            // last repeat done, channel stops where it is
                            chan_running[c] = 1'b0;
                            m.finished_events[c] = 1'b1;
                        end
                        else begin
                            // zero repeats forever, above one counts down
                            if (repeats_left[c] > REPEAT_LAST)
                                repeats_left[c] = repeats_left[c] - 1'b1;
                            elapsed_ticks[c] = '0;
                        end
                    end
                end
            end
        end
        else if (int'(ch) < CHANNELS) begin
            case (cmd)
                CMD_START:
                begin
                    // a start on a running channel restarts it, repeats kept
                    elapsed_ticks[ch] = '0;
                    compare_hit[ch]   = 1'b0;
                    chan_running[ch]  = 1'b1;
                end
                CMD_STOP:        chan_running[ch]  = 1'b0;
                // restart leaves compare-done and running alone
                CMD_RESTART:     elapsed_ticks[ch] = '0;
                CMD_SET_PERIOD:  period_ticks[ch]  = val;
                CMD_SET_COMPARE: compare_ticks[ch] = val;
                CMD_SET_REPEAT:  repeats_left[ch]  = val;
                default:         ;
            endcase
        end
        for (int c = 0; c < CHANNELS; c++)
            m.active_mask[c] = chan_running[c];
        return m;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [EV_W-1:0] got,
                               input logic [EV_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // present one item, hold it until taken, then maybe idle a while
    task automatic send_item(input logic [2:0] cmd, input logic [CH_W-1:0] ch,
                             input logic [VAL_W-1:0] val);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(IN_DATA_W - CH_W - VAL_W){1'b0}}, val, ch};
        do
            @(posedge clk);
        while (!s_tready);
        expected_masks.push_back(timer_step(cmd, ch, val));
        items_sent++;
        if (cmd == CMD_TICK)
            ticks_sent++;
        gap = src_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // lower valid and hold off until every owed result has come back
    task automatic wait_for_drain();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (expected_masks.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    // result side: random stalls on tready
    always @(posedge clk)
    begin
        if (sink_hold > 0)
        begin
            m_tready <= 1'b0;
            sink_hold--;
        end
        else if (sink_stalls && $urandom_range(0, 5) == 0)
        begin
            m_tready <= 1'b0;
            sink_hold = pick_gap();
        end
        else
            m_tready <= 1'b1;
    end

    // every accepted result against the oldest owed one
    always @(posedge clk)
    begin : result_check
        masks_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (expected_masks.size() == 0)
                report_mismatch($sformatf("result %h with nothing owed", m_tdata));
            else
            begin
                want = expected_masks.pop_front();
                check_field("compare_events", m_tdata[7:0], want.compare_events);
                check_field("period_events", m_tdata[15:8], want.period_events);
                check_field("finished_events", m_tdata[23:16], want.finished_events);
                check_field("active_mask", m_tdata[31:24], want.active_mask);
                period_seen   += $countones(want.period_events);
                finished_seen += $countones(want.finished_events);
            end
        end
    end

    always @(posedge clk)
        cycle_count++;

    // hang guard
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("timeout after %0d cycles, %0d results still owed",
                 cycle_count, expected_masks.size());
        $display("Mismatches found");
        $finish;
    end

    // nothing running: ticks are quiet, unused code 7 is ignored, stop is harmless
    task automatic test_reset_state();
        send_item(CMD_TICK, 3'd0, '0);
        send_item(CMD_UNUSED, 3'd7, COUNT_MAX);
        send_item(CMD_STOP, 3'd0, '0);
    endtask

    // one-shot channel: compare then period with finish, then restart while stopped
    task automatic test_single_shot();
        send_item(CMD_SET_PERIOD, 3'd0, 32'd2);
        send_item(CMD_SET_COMPARE, 3'd0, 32'd1);
        send_item(CMD_SET_REPEAT, 3'd0, REPEAT_LAST);
        send_item(CMD_START, 3'd0, '0);
        send_item(CMD_TICK, 3'd0, '0);
        send_item(CMD_TICK, 3'd5, '0);
        send_item(CMD_RESTART, 3'd0, '0);
        send_item(CMD_TICK, 3'd0, '0);
    endtask

    // zero period and compare fire on every tick, forever; start while running
    task automatic test_zero_period();
        send_item(CMD_SET_PERIOD, 3'd7, '0);
        send_item(CMD_START, 3'd7, '0);
        send_item(CMD_TICK, 3'd7, '0);
        send_item(CMD_TICK, 3'd2, COUNT_MAX);
        send_item(CMD_START, 3'd7, '0);
        send_item(CMD_STOP, 3'd7, '0);
    endtask

    // all-ones period, compare and repeat; saturation itself needs 2**32 ticks
    task automatic test_wide_values();
        send_item(CMD_SET_PERIOD, 3'd3, COUNT_MAX);
        send_item(CMD_SET_COMPARE, 3'd3, COUNT_MAX);
        send_item(CMD_SET_REPEAT, 3'd3, COUNT_MAX);
        send_item(CMD_START, 3'd3, '0);
        send_item(CMD_TICK, 3'd0, '0);
        send_item(CMD_TICK, 3'd0, '0);
        send_item(CMD_STOP, 3'd3, COUNT_MAX);
    endtask

    // mostly ticks over channels set up with short periods, plus command noise
    task automatic test_random_traffic(input int n_items);
        int               stop_at;
        int               r;
        logic [CH_W-1:0]  ch;
        logic [VAL_W-1:0] per;
        logic [VAL_W-1:0] cmp;
        logic [VAL_W-1:0] rpt;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            r  = $urandom_range(0, 99);
            ch = CH_W'($urandom_range(0, CHANNELS - 1));
            if (r < 10)
            begin
                // full channel setup: period, compare, repeat, start
                r = $urandom_range(0, 99);
                per = (r < 80) ? $urandom_range(0, 6) :
                      (r < 95) ? $urandom_range(7, 40) : $urandom();
                cmp = ($urandom_range(0, 99) < 85) ?
                      $urandom_range(0, (per > 40) ? 41 : per + 1) : $urandom();
                r = $urandom_range(0, 99);
                rpt = (r < 30) ? 0 : (r < 85) ? $urandom_range(1, 4) : $urandom();
                send_item(CMD_SET_PERIOD, ch, per);
                send_item(CMD_SET_COMPARE, ch, cmp);
                send_item(CMD_SET_REPEAT, ch, rpt);
                send_item(CMD_START, ch, $urandom());
            end
            else if (r < 75)
                // channel and value are don't-care on a tick
                send_item(CMD_TICK, ch, $urandom());
            else if (r < 80)
                send_item(CMD_START, ch, $urandom());
            else if (r < 85)
                send_item(CMD_STOP, ch, $urandom());
            else if (r < 90)
                send_item(CMD_RESTART, ch, $urandom());
            else if (r < 97)
                // lone set command, small or full-width value
                send_item(3'($urandom_range(CMD_SET_PERIOD, CMD_SET_REPEAT)), ch,
                          ($urandom_range(0, 1) != 0) ? $urandom_range(0, 8) : $urandom());
            else
                send_item(CMD_UNUSED, ch, $urandom());
        end
    endtask

    initial
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            elapsed_ticks[c] = '0;
            period_ticks[c]  = '0;
            compare_ticks[c] = '0;
            repeats_left[c]  = '0;
            chan_running[c]  = 1'b0;
            compare_hit[c]   = 1'b0;
        end
        repeat (RESET_LEN) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed cases back to back with no stalls
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        test_reset_state();
        test_single_shot();
        test_zero_period();
        test_wide_values();

        // random traffic with gaps on both sides
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        test_random_traffic(300);

        // sender holds off until everything owed is back
        wait_for_drain();

        // full rate stretch, then only the result side stalls
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        test_random_traffic(150);
        sink_stalls = 1'b1;
        test_random_traffic(100);

        src_gaps = 1'b1;
        test_random_traffic(350);

        // final drain and settle
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_masks.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_masks.size()));

        $display("sent %0d items (%0d ticks), checked %0d results in %0d cycles",
                 items_sent, ticks_sent, results_seen, cycle_count);
        $display("saw %0d period events and %0d finished events across %0d channels",
                 period_seen, finished_seen, CHANNELS);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
